@@ hdl/lppp_pkg.sv @@
package lppp_pkg;

    localparam int COEF_WORDS  = 21;
    localparam int PIX_AW      = 20;
    localparam int PIXELS      = 1 << PIX_AW;
    localparam int MAX_CLASSES = 11;
    localparam int CLASS_W     = 4;
    localparam int DIM_W       = 11;
    localparam int DIV_STAGES  = DIM_W;
    localparam int NUM_W       = 32 + DIM_W;
    localparam int NSTG        = 18;
    localparam int IN_TDATA_W  = 216;
    localparam int OUT_TDATA_W = 176;

    localparam logic signed [31:0] DEPTH_MIN = 32'sd655;
    localparam logic [7:0]         LABEL_BYTE_W = 8'd8;

    localparam logic [1:0] REQ_LABEL = 2'd0;
    localparam logic [1:0] REQ_COEF  = 2'd1;
    localparam logic [1:0] REQ_POINT = 2'd2;

    localparam logic [1:0] CFG_CLASS_COUNT  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        logic [1:0]        req;
        logic [PIX_AW-1:0] addr;
        logic [7:0]        label_value;
        word_t             x;
        word_t             y;
        word_t             z;
        word_t             intensity;
        word_t             pt_time;
    } item_t;

    typedef struct packed {
        word_t                  x;
        word_t                  y;
        word_t                  z;
        word_t                  intensity;
        word_t                  pt_time;
        logic [CLASS_W-1:0]     label;
        logic [MAX_CLASSES-1:0] one_hot;
    } result_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [PIX_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

@@ hdl/lppp_xform.sv @@
module lppp_xform import lppp_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t mat [9],
    input  word_t off [3],
    input  word_t vec [3],
    output word_t res [3]
);

    logic signed [63:0] prod_reg [9];
    word_t              res_reg  [3];
    logic signed [63:0] sum_next [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= mat[i] * vec[i % 3];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = 64'(off[r]) + (prod_reg[r*3] >>> 16)
                        + (prod_reg[r*3+1] >>> 16) + (prod_reg[r*3+2] >>> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (sum_next[r] > 64'sh7FFFFFFF)
                begin
                    res_reg[r] <= 32'sh7FFFFFFF;
                end
                else if (sum_next[r] < -64'sh80000000)
                begin
                    res_reg[r] <= -32'sh80000000;
                end
                else
                begin
                    res_reg[r] <= sum_next[r][31:0];
                end
            end
        end
    end

    assign res = res_reg;

endmodule

@@ hdl/lppp_div.sv @@
module lppp_div import lppp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [31:0]        den,
    output logic [DIM_W-1:0]   quo
);

    logic [NUM_W-1:0] rem_reg [DIV_STAGES];
    logic [31:0]      den_reg [DIV_STAGES];
    logic [DIM_W-1:0] quo_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [31:0]      den_in;
        logic [DIM_W-1:0] quo_in;
        logic [NUM_W-1:0] shifted;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign shifted = NUM_W'(den_in) << (DIV_STAGES - 1 - s);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s] <= den_in;
                if (rem_in >= shifted)
                begin
                    rem_reg[s] <= rem_in - shifted;
                    quo_reg[s] <= quo_in | (DIM_W'(1) << (DIV_STAGES - 1 - s));
                end
                else
                begin
                    rem_reg[s] <= rem_in;
                    quo_reg[s] <= quo_in;
                end
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

@@ hdl/lppp_label.sv @@
module lppp_label import lppp_pkg::*;
(
    input  logic                   clk,
    input  mem_req_t               req,
    input  logic [CLASS_W-1:0]     class_count,
    output logic [CLASS_W-1:0]     label,
    output logic [MAX_CLASSES-1:0] one_hot
);

    logic [7:0]         mem [PIXELS];
    logic [7:0]         rd_reg;
    logic [7:0]         cnt;
    logic [7:0]         lab;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            rd_reg <= mem[req.addr];
        end
    end

    always_comb
    begin
        cnt = 8'(class_count);
        if (cnt < 8'd1)
        begin
            cnt = 8'd1;
        end
        if (cnt > 8'(MAX_CLASSES))
        begin
            cnt = 8'(MAX_CLASSES);
        end
        lab = rd_reg;
        if (lab >= cnt)
        begin
            lab = cnt - 8'd1;
        end
        label   = lab[CLASS_W-1:0];
        one_hot = MAX_CLASSES'(1) << lab[CLASS_W-1:0];
    end

endmodule

@@ hdl/lidar_point_projection_painting_core.sv @@
// Channel   Direction  Handshake                  Item
// s_axis    in         tvalid / tready            load label, load coefficient, point
// m_axis    out        tvalid / tready            painted point
// apb       in/out     psel, penable, pready      class count, image width, image height
//
// A point item enters every cycle unless the pipeline stalls; its depth is set by the two
// matrix transforms, the sign-fold register, the 11-step quotient pipeline, the pixel
// address register and the label memory read. A coefficient load waits until no item is
// in flight. Reset clears the valid line and the output buffer count and pointers and
// sets the registers to their defaults; the tables hold nothing defined until loaded.
// The pipeline stalls only when both output buffer entries are full.
module lidar_point_projection_painting_core import lppp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // load_addr, load_value, pt_x, pt_y, pt_z, pt_intensity, pt_time, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_x, out_y, out_z, out_intensity, out_time, class_label, class_one_hot, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [CLASS_W-1:0] class_count_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic               cfg_we;

    word_t              coef_reg [COEF_WORDS];
    logic               coef_we;

    logic [NSTG-1:0]    vld_reg;
    logic [NSTG-1:0]    vld_next;
    item_t              pay_reg [NSTG];
    item_t              in_item;
    logic               en;
    logic               pipe_busy;
    logic               accept;

    word_t              mat1 [9];
    word_t              off1 [3];
    word_t              vec1 [3];
    word_t              cam  [3];
    word_t              mat2 [9];
    word_t              off2 [3];
    word_t              img  [3];

    logic [32:0]        nx_reg;
    logic [32:0]        ny_reg;
    logic [31:0]        ad_reg;
    logic [NUM_W-1:0]   wad_reg;
    logic [NUM_W-1:0]   had_reg;
    logic [32:0]        nx_next;
    logic [32:0]        ny_next;
    logic [31:0]        ad_next;
    logic               in_bounds;

    logic [DIM_W-1:0]   col_q;
    logic [DIM_W-1:0]   row_q;
    logic [DIM_W-1:0]   col_c;
    logic [DIM_W-1:0]   row_c;
    logic [2*DIM_W-1:0] row_base;
    logic [PIX_AW-1:0]  pix_reg;

    mem_req_t           mem_req;
    logic [CLASS_W-1:0]     lab;
    logic [MAX_CLASSES-1:0] lab_one_hot;

    result_t            fifo_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic               push;
    logic               pop;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg  <= CLASS_W'(MAX_CLASSES);
            image_width_reg  <= DIM_W'(1024);
            image_height_reg <= DIM_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                CFG_CLASS_COUNT:  class_count_reg  <= pwdata[CLASS_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_CLASS_COUNT:  prdata = 32'(class_count_reg);
            CFG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            CFG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Input side.
    assign in_item.req         = s_axis_tuser;
    assign in_item.addr        = s_axis_tdata[19:0];
    assign in_item.label_value = s_axis_tdata[27:20];
    assign in_item.x           = s_axis_tdata[83:52];
    assign in_item.y           = s_axis_tdata[115:84];
    assign in_item.z           = s_axis_tdata[147:116];
    assign in_item.intensity   = s_axis_tdata[179:148];
    assign in_item.pt_time     = s_axis_tdata[211:180];

    assign en            = (cnt_reg != 2'd2);
    assign pipe_busy     = |vld_reg;
    assign s_axis_tready = en && !((s_axis_tuser == REQ_COEF) && pipe_busy);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign coef_we       = accept && (s_axis_tuser == REQ_COEF)
                           && (in_item.addr < PIX_AW'(COEF_WORDS));

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_reg[in_item.addr[4:0]] <= s_axis_tdata[51:20];
        end
    end

    // Matrix stages.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            mat1[i] = coef_reg[(i / 3) * 4 + (i % 3)];
            mat2[i] = coef_reg[12 + i];
        end
        for (int r = 0; r < 3; r++)
        begin
            off1[r] = coef_reg[r * 4 + 3];
            off2[r] = '0;
        end
        vec1[0] = in_item.x;
        vec1[1] = in_item.y;
        vec1[2] = in_item.z;
    end

    lppp_xform u_cam
    (
        .clk (clk),
        .en  (en),
        .mat (mat1),
        .off (off1),
        .vec (vec1),
        .res (cam)
    );

    lppp_xform u_img
    (
        .clk (clk),
        .en  (en),
        .mat (mat2),
        .off (off2),
        .vec (cam),
        .res (img)
    );

    // Sign-folded numerators and scaled bounds.
    always_comb
    begin
        if (img[2] < 0)
        begin
            nx_next = -33'(img[0]);
            ny_next = -33'(img[1]);
            ad_next = 32'(-33'(img[2]));
        end
        else
        begin
            nx_next = 33'(img[0]);
            ny_next = 33'(img[1]);
            ad_next = img[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            ad_reg  <= ad_next;
            wad_reg <= NUM_W'(image_width_reg) * NUM_W'(ad_next);
            had_reg <= NUM_W'(image_height_reg) * NUM_W'(ad_next);
        end
    end

    assign in_bounds = !nx_reg[32] && (nx_reg != '0) && (NUM_W'(nx_reg) <= wad_reg)
                    && !ny_reg[32] && (ny_reg != '0) && (NUM_W'(ny_reg) <= had_reg);

    lppp_div u_col
    (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(nx_reg)),
        .den (ad_reg),
        .quo (col_q)
    );

    lppp_div u_row
    (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(ny_reg)),
        .den (ad_reg),
        .quo (row_q)
    );

    // Pixel address with the right and bottom edges clamped.
    always_comb
    begin
        col_c    = (col_q >= image_width_reg)  ? image_width_reg - DIM_W'(1)  : col_q;
        row_c    = (row_q >= image_height_reg) ? image_height_reg - DIM_W'(1) : row_q;
        row_base = row_c * image_width_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= row_base[PIX_AW-1:0] + PIX_AW'(col_c);
        end
    end

    // Item valid line, with points dropped at the depth, divisor and bounds checks.
    always_comb
    begin
        vld_next[0] = accept && ((s_axis_tuser == REQ_LABEL) || (s_axis_tuser == REQ_POINT));
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
        if (pay_reg[1].req == REQ_POINT && cam[2] < DEPTH_MIN)
        begin
            vld_next[2] = 1'b0;
        end
        if (pay_reg[3].req == REQ_POINT && img[2] == '0)
        begin
            vld_next[4] = 1'b0;
        end
        if (pay_reg[4].req == REQ_POINT && !in_bounds)
        begin
            vld_next[5] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= in_item;
            for (int k = 1; k < NSTG; k++)
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    // Label memory: loads and point reads meet it at the same stage, in order.
    always_comb
    begin
        mem_req.en    = en;
        mem_req.we    = vld_reg[NSTG-2] && (pay_reg[NSTG-2].req == REQ_LABEL);
        mem_req.addr  = (pay_reg[NSTG-2].req == REQ_LABEL) ? pay_reg[NSTG-2].addr : pix_reg;
        mem_req.wdata = pay_reg[NSTG-2].label_value;
    end

    lppp_label u_label
    (
        .clk         (clk),
        .req         (mem_req),
        .class_count (class_count_reg),
        .label       (lab),
        .one_hot     (lab_one_hot)
    );

    // Two-entry output buffer.
    assign push = en && vld_reg[NSTG-1] && (pay_reg[NSTG-1].req == REQ_POINT);
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].x         <= pay_reg[NSTG-1].x;
            fifo_reg[wr_ptr_reg].y         <= pay_reg[NSTG-1].y;
            fifo_reg[wr_ptr_reg].z         <= pay_reg[NSTG-1].z;
            fifo_reg[wr_ptr_reg].intensity <= pay_reg[NSTG-1].intensity;
            fifo_reg[wr_ptr_reg].pt_time   <= pay_reg[NSTG-1].pt_time;
            fifo_reg[wr_ptr_reg].label     <= lab;
            fifo_reg[wr_ptr_reg].one_hot   <= lab_one_hot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {1'b0,
                            fifo_reg[rd_ptr_reg].one_hot,
                            fifo_reg[rd_ptr_reg].label,
                            fifo_reg[rd_ptr_reg].pt_time,
                            fifo_reg[rd_ptr_reg].intensity,
                            fifo_reg[rd_ptr_reg].z,
                            fifo_reg[rd_ptr_reg].y,
                            fifo_reg[rd_ptr_reg].x};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("output buffer overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tdata[174:164]))
        else $error("class mask is not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    assert property (@(posedge clk) disable iff (!rst_n) coef_we |-> !pipe_busy)
        else $error("coefficient written with items in flight");
`endif

endmodule
